### hdl/mbd_pkg.sv
// Package for the Manchester bit decoder.
// Holds the item, result and configuration types and the status, phase and register codes.
// Used by mbd_step and manchester_bit_decoder_unit; depends on nothing.
package mbd_pkg;

	localparam int TICK_COUNTER_BITS_DEF = 16;
	localparam int CFG_DATA_BITS = 16;
	localparam int CFG_INDEX_BITS = 3;

	// register indexes
	localparam logic [CFG_INDEX_BITS-1:0] CFG_CARRIER_PERIOD = 3'd0;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_BIT_COUNT = 3'd1;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_MSB_FIRST = 3'd2;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_PREAMBLE_EDGES = 3'd3;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_PREAMBLE_TIMEOUT = 3'd4;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_BIT_TIMEOUT = 3'd5;

	// register reset values
	localparam logic [7:0] CARRIER_PERIOD_RST = 8'd32;
	localparam logic [7:0] BIT_COUNT_RST = 8'd72;
	localparam logic MSB_FIRST_RST = 1'b1;
	localparam logic [4:0] PREAMBLE_EDGES_RST = 5'd16;
	localparam logic [15:0] PREAMBLE_TIMEOUT_RST = 16'd65535;
	localparam logic [15:0] BIT_TIMEOUT_RST = 16'd65535;

	// accepted bit periods
	localparam logic [7:0] PERIOD_16 = 8'd16;
	localparam logic [7:0] PERIOD_32 = 8'd32;
	localparam logic [7:0] PERIOD_40 = 8'd40;
	localparam logic [7:0] PERIOD_64 = 8'd64;

	// status codes
	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_BUSY = 3'd1;
	localparam logic [2:0] ST_DONE = 3'd2;
	localparam logic [2:0] ST_PRE_TIMEOUT = 3'd3;
	localparam logic [2:0] ST_DECODE_ERR = 3'd4;
	localparam logic [2:0] ST_BAD_PERIOD = 3'd5;

	typedef enum logic [7:0] {
		PH_IDLE = 8'b0000_0001,
		PH_WAIT_LOW = 8'b0000_0010,
		PH_PREAMBLE = 8'b0000_0100,
		PH_REF = 8'b0000_1000,
		PH_FRONT = 8'b0001_0000,
		PH_BEHIND = 8'b0010_0000,
		PH_BIT_OK = 8'b0100_0000,
		PH_FINISHED = 8'b1000_0000
	} phase_t;

	typedef struct packed {
		logic cmd;
		logic level;
	} item_t;

	typedef struct packed {
		logic bit_valid;
		logic bit_value;
		logic [7:0] bit_index;
		logic [2:0] bit_position;
		logic [2:0] status;
	} result_t;

	typedef struct packed {
		logic [7:0] carrier_period;
		logic [7:0] bit_count;
		logic msb_first;
		logic [4:0] preamble_edges;
		logic [15:0] preamble_timeout;
		logic [15:0] bit_timeout;
	} cfg_t;

endpackage

### hdl/manchester_bit_decoder_unit.sv
// Top level of the Manchester bit decoder: configuration registers, input and result stages.
// Instantiates mbd_step; depends on mbd_pkg.
//
// Usage:
//  Input channel (item_valid, item_stall, item): one item per timer tick of 0.5 us, or a
//  start command (cmd = 1) that arms a reception. Result channel (result_valid,
//  result_stall, result): exactly one result per item, in order, carrying a decoded bit
//  when one completes on that tick and the current status.
//  A result passes through the input stage and the state update into the result stage;
//  throughput is one item per cycle while the receiver does not stall, set by the
//  state update between the input and result stages.
//  Configuration is written through cfg_write/cfg_index/cfg_data while no reception is
//  in flight; indexes past the last register are ignored.
//  Reset clears the decoder to idle with status idle and loads the register defaults.
//  When the receiver stalls, the result stage holds and the input stage holds its item;
//  item_stall rises only once both stages are full.
module manchester_bit_decoder_unit import mbd_pkg::*; #(
	parameter int TICK_COUNTER_BITS = TICK_COUNTER_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic item_valid,
	output logic item_stall,
	input item_t item,
	output logic result_valid,
	input logic result_stall,
	output result_t result,
	input logic cfg_write,
	input logic [CFG_INDEX_BITS-1:0] cfg_index,
	input logic [CFG_DATA_BITS-1:0] cfg_data
);

	cfg_t cfg_q;
	item_t item_s1;
	logic valid_s1;
	result_t result_s2;
	logic valid_s2;
	result_t step_result;
	logic go;

	assign go = valid_s1 && (!valid_s2 || !result_stall);
	assign item_stall = valid_s1 && valid_s2 && result_stall;
	assign result_valid = valid_s2;
	assign result = result_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.carrier_period <= CARRIER_PERIOD_RST;
			cfg_q.bit_count <= BIT_COUNT_RST;
			cfg_q.msb_first <= MSB_FIRST_RST;
			cfg_q.preamble_edges <= PREAMBLE_EDGES_RST;
			cfg_q.preamble_timeout <= PREAMBLE_TIMEOUT_RST;
			cfg_q.bit_timeout <= BIT_TIMEOUT_RST;
		end else if (cfg_write) begin
			unique case (cfg_index)
				CFG_CARRIER_PERIOD: cfg_q.carrier_period <= cfg_data[7:0];
				CFG_BIT_COUNT: cfg_q.bit_count <= cfg_data[7:0];
				CFG_MSB_FIRST: cfg_q.msb_first <= cfg_data[0];
				CFG_PREAMBLE_EDGES: cfg_q.preamble_edges <= cfg_data[4:0];
				CFG_PREAMBLE_TIMEOUT: cfg_q.preamble_timeout <= cfg_data;
				CFG_BIT_TIMEOUT: cfg_q.bit_timeout <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_valid && !item_stall) begin
			valid_s1 <= 1'b1;
		end else if (go) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			item_s1 <= item;
		end
	end

	mbd_step #(
		.TICK_COUNTER_BITS(TICK_COUNTER_BITS)
	) u_step (
		.clk(clk),
		.arst_n(arst_n),
		.step(go),
		.item(item_s1),
		.cfg(cfg_q),
		.result(step_result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (go) begin
			valid_s2 <= 1'b1;
		end else if (!result_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			result_s2 <= step_result;
		end
	end

`ifndef NO_ASSERTIONS
	a_bit_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && result_s2.bit_valid |-> result_s2.status == ST_BUSY)
		else $error("bit emitted outside a busy reception");

	a_no_bit_fields_zero: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !result_s2.bit_valid |->
		result_s2.bit_value == 1'b0 && result_s2.bit_index == '0 &&
		result_s2.bit_position == '0)
		else $error("bit fields set without a bit");

	a_position_match: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && result_s2.bit_valid |->
		result_s2.bit_position == result_s2.bit_index[2:0] ||
		result_s2.bit_position == ~result_s2.bit_index[2:0])
		else $error("bit position does not follow bit index");

	a_result_from_stage: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(valid_s2) |-> $past(valid_s1))
		else $error("result without an item in the input stage");
`endif

endmodule

### hdl/mbd_step.sv
// Decoder state and per-item update logic of the Manchester bit decoder.
// Holds the reception state and computes one result per item from it.
// Depends on mbd_pkg.
module mbd_step import mbd_pkg::*; #(
	parameter int TICK_COUNTER_BITS = TICK_COUNTER_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic step,
	input item_t item,
	input cfg_t cfg,
	output result_t result
);

	localparam int W = TICK_COUNTER_BITS;
	localparam int CW = (W > 16) ? W : 16;
	localparam logic [W-1:0] TICK_MAX = {W{1'b1}};

	phase_t phase_q, phase_nxt;
	logic [W-1:0] elapsed_q, elapsed_nxt;
	logic [W-1:0] edge_time_q, edge_time_nxt;
	logic ref_level_q, ref_level_nxt;
	logic last_level_q, last_level_nxt;
	logic [4:0] edges_q, edges_nxt;
	logic [7:0] bits_q, bits_nxt;
	logic [2:0] status_q, status_nxt;

	logic [8:0] eighth;
	logic [CW-1:0] t_ext, pre_to, bit_to, ref_time, limit_time, next_time, eighth_ext;
	logic [W-1:0] t;
	logic [CW-1:0] since_edge;
	logic period_ok;
	logic [4:0] edges_inc;
	logic [7:0] bits_inc;

	assign eighth = {cfg.carrier_period, 1'b0};
	assign t = (elapsed_q == TICK_MAX) ? elapsed_q : elapsed_q + 1'b1;
	assign t_ext = CW'(t);
	assign pre_to = CW'(cfg.preamble_timeout);
	assign bit_to = CW'(cfg.bit_timeout);
	assign ref_time = CW'({eighth, 1'b0});
	assign limit_time = CW'({eighth, 3'b000});
	assign next_time = CW'({eighth, 2'b00});
	assign eighth_ext = CW'(eighth);
	assign since_edge = CW'(t - edge_time_q);
	assign period_ok = (cfg.carrier_period == PERIOD_16) || (cfg.carrier_period == PERIOD_32) ||
		(cfg.carrier_period == PERIOD_40) || (cfg.carrier_period == PERIOD_64);
	assign edges_inc = edges_q + 5'd1;
	assign bits_inc = bits_q + 8'd1;

	always_comb begin
		phase_nxt = phase_q;
		elapsed_nxt = elapsed_q;
		edge_time_nxt = edge_time_q;
		ref_level_nxt = ref_level_q;
		last_level_nxt = last_level_q;
		edges_nxt = edges_q;
		bits_nxt = bits_q;
		status_nxt = status_q;
		result = '0;

		if (item.cmd) begin
			elapsed_nxt = '0;
			edge_time_nxt = '0;
			ref_level_nxt = 1'b0;
			last_level_nxt = 1'b0;
			edges_nxt = '0;
			bits_nxt = '0;
			if (period_ok) begin
				phase_nxt = PH_WAIT_LOW;
				status_nxt = ST_BUSY;
			end else begin
				phase_nxt = PH_FINISHED;
				status_nxt = ST_BAD_PERIOD;
			end
		end else begin
			unique case (phase_q)
				PH_IDLE, PH_FINISHED: begin
				end
				PH_WAIT_LOW, PH_PREAMBLE: begin
					elapsed_nxt = t;
					priority if (t_ext > pre_to) begin
						phase_nxt = PH_FINISHED;
						status_nxt = ST_PRE_TIMEOUT;
					end else if (phase_q == PH_WAIT_LOW) begin
						if (!item.level) begin
							last_level_nxt = 1'b0;
							if (cfg.preamble_edges == '0) begin
								elapsed_nxt = '0;
								if (bits_q >= cfg.bit_count) begin
									phase_nxt = PH_FINISHED;
									status_nxt = ST_DONE;
								end else begin
									phase_nxt = PH_REF;
								end
							end else begin
								phase_nxt = PH_PREAMBLE;
							end
						end
					end else if (item.level != last_level_q) begin
						last_level_nxt = item.level;
						edges_nxt = edges_inc;
						if (edges_inc == cfg.preamble_edges) begin
							elapsed_nxt = '0;
							if (bits_q >= cfg.bit_count) begin
								phase_nxt = PH_FINISHED;
								status_nxt = ST_DONE;
							end else begin
								phase_nxt = PH_REF;
							end
						end
					end
				end
				PH_REF, PH_FRONT, PH_BEHIND, PH_BIT_OK: begin
					elapsed_nxt = t;
					priority if (t_ext > bit_to) begin
						phase_nxt = PH_FINISHED;
						status_nxt = ST_DECODE_ERR;
					end else if (phase_q == PH_REF) begin
						if (t_ext >= ref_time) begin
							ref_level_nxt = item.level;
							phase_nxt = PH_FRONT;
						end
					end else if (phase_q == PH_FRONT) begin
						priority if (t_ext >= limit_time) begin
							phase_nxt = PH_FINISHED;
							status_nxt = ST_DECODE_ERR;
						end else if (item.level != ref_level_q) begin
							edge_time_nxt = t;
							phase_nxt = PH_BEHIND;
						end else begin
						end
					end else if (phase_q == PH_BEHIND) begin
						if (since_edge >= eighth_ext) begin
							if (item.level != ref_level_q) begin
								result.bit_valid = 1'b1;
								result.bit_value = item.level;
								result.bit_index = bits_q;
								result.bit_position = cfg.msb_first ? ~bits_q[2:0] : bits_q[2:0];
								phase_nxt = PH_BIT_OK;
							end else begin
								phase_nxt = PH_FINISHED;
								status_nxt = ST_DECODE_ERR;
							end
						end
					end else begin
						if (since_edge >= next_time) begin
							bits_nxt = bits_inc;
							elapsed_nxt = '0;
							if (bits_inc >= cfg.bit_count) begin
								phase_nxt = PH_FINISHED;
								status_nxt = ST_DONE;
							end else begin
								phase_nxt = PH_REF;
							end
						end
					end
				end
				default: begin
				end
			endcase
		end

		result.status = status_nxt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			elapsed_q <= '0;
			edge_time_q <= '0;
			ref_level_q <= 1'b0;
			last_level_q <= 1'b0;
			edges_q <= '0;
			bits_q <= '0;
			status_q <= ST_IDLE;
		end else if (step) begin
			phase_q <= phase_nxt;
			elapsed_q <= elapsed_nxt;
			edge_time_q <= edge_time_nxt;
			ref_level_q <= ref_level_nxt;
			last_level_q <= last_level_nxt;
			edges_q <= edges_nxt;
			bits_q <= bits_nxt;
			status_q <= status_nxt;
		end
	end

endmodule
